FILE: rtl/bmpblt_pkg.sv
`default_nettype none
package bmpblt_pkg;

  localparam int DIM_W = 13;
  localparam int ORG_W = 11;
  localparam int CFG_IDX_W = 2;

  localparam int ITEM_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 4;

  // header byte positions
  localparam logic [4:0] OFS_SIG0 = 5'h00;
  localparam logic [4:0] OFS_SIG1 = 5'h01;
  localparam logic [4:0] OFS_DATA = 5'h0a;
  localparam logic [4:0] OFS_WIDTH = 5'h12;
  localparam logic [4:0] OFS_HEIGHT = 5'h16;
  localparam logic [31:0] HEADER_END = 32'h1a;

  localparam logic [7:0] SIG_FIRST = 8'h42;
  localparam logic [7:0] SIG_SECOND = 8'h4d;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MODE = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0,
    ST_DONE = 3'd1,
    ST_NOT_BMP = 3'd2,
    ST_TRUNC = 3'd3,
    ST_BAD_SIZE = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [11:0] color;
    status_t     status;
  } out_item_t;

  // work item between front and back
  typedef struct packed {
    logic             is_pixel;
    logic [DIM_W-1:0] column;
    logic [DIM_W-1:0] img_row;
    logic [11:0]      color;
    status_t          status;
  } job_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } img_dims_t;

  typedef struct packed {
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic             center_mode;
  } cfg_regs_t;

endpackage
`default_nettype wire

FILE: rtl/bmpblt_fifo.sv
`default_nettype none
module bmpblt_fifo #(
  parameter type item_t = logic,
  parameter int DEPTH = 4
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  item_t wr_data,
  output logic  full,
  input  wire   pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full = (count_r == CNT_FULL);
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bmpblt_front.sv
`default_nettype none
module bmpblt_front #(
  parameter int MAX_DIM = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  byte_valid,
  input  bmpblt_pkg::in_item_t byte_in,
  output logic                 job_push,
  output bmpblt_pkg::job_t     job,
  output bmpblt_pkg::img_dims_t dims
);

  localparam int DW = bmpblt_pkg::DIM_W;
  localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS,
    PH_FINISHED
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [31:0]   byte_offset_r, byte_offset_nxt;
  logic [31:0]   data_start_r, data_start_nxt;
  logic [31:0]   field_acc_r, field_acc_nxt;
  logic [DW-1:0] image_width_r, image_width_nxt;
  logic [DW-1:0] image_height_r, image_height_nxt;
  logic          top_down_r, top_down_nxt;
  logic [DW-1:0] column_count_r, column_count_nxt;
  logic [DW-1:0] row_count_r, row_count_nxt;
  logic [1:0]    byte_in_pixel_r, byte_in_pixel_nxt;
  logic [7:0]    blue_hold_r, blue_hold_nxt;
  logic [7:0]    green_hold_r, green_hold_nxt;
  logic [7:0]    first_byte_hold_r, first_byte_hold_nxt;

  logic [7:0]    b;
  logic [4:0]    hdr_off;
  logic [31:0]   acc_full;
  logic [31:0]   mag;
  logic [DW-1:0] col_inc, row_inc;
  logic          emit_pixel;
  bmpblt_pkg::status_t status;

  assign b = byte_in.file_byte;
  assign hdr_off = byte_offset_r[4:0];
  // the field's top byte arrives with this beat
  assign acc_full = {b, field_acc_r[23:0]};
  assign mag = acc_full[31] ? (32'd0 - acc_full) : acc_full;
  assign col_inc = column_count_r + 1'b1;
  assign row_inc = row_count_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    byte_offset_nxt = byte_offset_r;
    data_start_nxt = data_start_r;
    field_acc_nxt = field_acc_r;
    image_width_nxt = image_width_r;
    image_height_nxt = image_height_r;
    top_down_nxt = top_down_r;
    column_count_nxt = column_count_r;
    row_count_nxt = row_count_r;
    byte_in_pixel_nxt = byte_in_pixel_r;
    blue_hold_nxt = blue_hold_r;
    green_hold_nxt = green_hold_r;
    first_byte_hold_nxt = first_byte_hold_r;
    status = bmpblt_pkg::ST_RUN;
    emit_pixel = 1'b0;

    if (byte_valid && phase_r != PH_FINISHED) begin
      case (phase_r)
        PH_HEADER: begin
          byte_offset_nxt = byte_offset_r + 1'b1;
          if (hdr_off == bmpblt_pkg::OFS_SIG0) begin
            first_byte_hold_nxt = b;
          end else if (hdr_off == bmpblt_pkg::OFS_SIG1) begin
            if (first_byte_hold_r != bmpblt_pkg::SIG_FIRST || b != bmpblt_pkg::SIG_SECOND) begin
              status = bmpblt_pkg::ST_NOT_BMP;
            end
          end else if (hdr_off inside {[bmpblt_pkg::OFS_DATA:bmpblt_pkg::OFS_DATA + 5'd3]})
          begin
            data_start_nxt[8 * 2'(hdr_off - bmpblt_pkg::OFS_DATA) +: 8] = b;
          end else if (hdr_off inside
                       {[bmpblt_pkg::OFS_WIDTH:bmpblt_pkg::OFS_WIDTH + 5'd3]}) begin
            field_acc_nxt[8 * 2'(hdr_off - bmpblt_pkg::OFS_WIDTH) +: 8] = b;
            if (hdr_off == bmpblt_pkg::OFS_WIDTH + 5'd3) begin
              if (acc_full == '0 || acc_full > MAX_DIM_W) begin
                status = bmpblt_pkg::ST_BAD_SIZE;
              end else begin
                image_width_nxt = acc_full[DW-1:0];
              end
              field_acc_nxt = '0;
            end
          end else if (hdr_off inside
                       {[bmpblt_pkg::OFS_HEIGHT:bmpblt_pkg::OFS_HEIGHT + 5'd3]}) begin
            field_acc_nxt[8 * 2'(hdr_off - bmpblt_pkg::OFS_HEIGHT) +: 8] = b;
            if (hdr_off == bmpblt_pkg::OFS_HEIGHT + 5'd3) begin
              if (acc_full[31]) begin
                top_down_nxt = 1'b1;
              end
              if (mag == '0 || mag > MAX_DIM_W) begin
                status = bmpblt_pkg::ST_BAD_SIZE;
              end else begin
                image_height_nxt = mag[DW-1:0];
                // data offset must lie past the header
                if (data_start_r < bmpblt_pkg::HEADER_END) begin
                  status = bmpblt_pkg::ST_NOT_BMP;
                end else if (data_start_r == bmpblt_pkg::HEADER_END) begin
                  phase_nxt = PH_PIXELS;
                end else begin
                  phase_nxt = PH_SKIP;
                end
              end
              field_acc_nxt = '0;
            end
          end
        end
        PH_SKIP: begin
          byte_offset_nxt = byte_offset_r + 1'b1;
          if (byte_offset_nxt == data_start_r) begin
            phase_nxt = PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          case (byte_in_pixel_r)
            2'd0: begin
              blue_hold_nxt = b;
              byte_in_pixel_nxt = 2'd1;
            end
            2'd1: begin
              green_hold_nxt = b;
              byte_in_pixel_nxt = 2'd2;
            end
            2'd2: begin
              emit_pixel = 1'b1;
              byte_in_pixel_nxt = 2'd3;
              column_count_nxt = col_inc;
              if (col_inc >= image_width_r) begin
                column_count_nxt = '0;
                row_count_nxt = row_inc;
                if (row_inc >= image_height_r) begin
                  status = bmpblt_pkg::ST_DONE;
                end
              end
            end
            default: begin
              byte_in_pixel_nxt = 2'd0;
            end
          endcase
        end
        default: begin
        end
      endcase

      if (status == bmpblt_pkg::ST_RUN && byte_in.last_byte) begin
        status = bmpblt_pkg::ST_TRUNC;
      end
      if (status != bmpblt_pkg::ST_RUN) begin
        phase_nxt = PH_FINISHED;
      end
    end
  end

  assign job_push = emit_pixel || (status != bmpblt_pkg::ST_RUN);

  always_comb begin
    job.is_pixel = emit_pixel;
    job.column = column_count_r;
    job.img_row = top_down_r ? row_count_r : (image_height_r - 1'b1 - row_count_r);
    job.color = {blue_hold_r[7:4], green_hold_r[7:4], b[7:4]};
    job.status = status;
  end

  assign dims.width = image_width_r;
  assign dims.height = image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      byte_offset_r <= '0;
      data_start_r <= '0;
      field_acc_r <= '0;
      image_width_r <= '0;
      image_height_r <= '0;
      top_down_r <= 1'b0;
      column_count_r <= '0;
      row_count_r <= '0;
      byte_in_pixel_r <= '0;
      blue_hold_r <= '0;
      green_hold_r <= '0;
      first_byte_hold_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      byte_offset_r <= byte_offset_nxt;
      data_start_r <= data_start_nxt;
      field_acc_r <= field_acc_nxt;
      image_width_r <= image_width_nxt;
      image_height_r <= image_height_nxt;
      top_down_r <= top_down_nxt;
      column_count_r <= column_count_nxt;
      row_count_r <= row_count_nxt;
      byte_in_pixel_r <= byte_in_pixel_nxt;
      blue_hold_r <= blue_hold_nxt;
      green_hold_r <= green_hold_nxt;
      first_byte_hold_r <= first_byte_hold_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bmpblt_back.sv
`default_nettype none
module bmpblt_back #(
  parameter int SCREEN_WIDTH = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   job_empty,
  output logic                  job_pop,
  input  bmpblt_pkg::job_t      job,
  input  bmpblt_pkg::img_dims_t dims,
  input  bmpblt_pkg::cfg_regs_t cfg,
  input  wire                   res_full,
  output logic                  res_push,
  output bmpblt_pkg::out_item_t res
);

  localparam int DW = bmpblt_pkg::DIM_W;
  localparam logic [DW-1:0] SCR_W = DW'(SCREEN_WIDTH);
  localparam logic [DW-1:0] SCR_H = DW'(SCREEN_HEIGHT);

  logic [DW-1:0] ox_r, ox_nxt;
  logic [DW-1:0] oy_r, oy_nxt;
  logic [DW-1:0] x, y;
  logic          on_screen, pv;

  // placement offsets, settled long before any pixel arrives
  always_comb begin
    if (cfg.center_mode) begin
      ox_nxt = (SCR_W > dims.width) ? ((SCR_W - dims.width) >> 1) : '0;
      oy_nxt = (SCR_H > dims.height) ? ((SCR_H - dims.height) >> 1) : '0;
    end else begin
      ox_nxt = DW'(cfg.origin_x);
      oy_nxt = DW'(cfg.origin_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
    end else begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
  end

  assign x = ox_r + job.column;
  assign y = oy_r + job.img_row;
  assign on_screen = (x < SCR_W) && (y < SCR_H);
  assign pv = job.is_pixel && on_screen;

  assign job_pop = !job_empty && !res_full;
  // clipped pixels with no status leave nothing behind
  assign res_push = job_pop && (pv || job.status != bmpblt_pkg::ST_RUN);

  always_comb begin
    res.pixel_valid = pv;
    res.pixel_x = pv ? x[9:0] : '0;
    res.pixel_y = pv ? y[8:0] : '0;
    res.color = pv ? job.color : '0;
    res.status = job.status;
  end

endmodule
`default_nettype wire

FILE: rtl/bmp32_to_rgb444_blitter_core.sv
`default_nettype none
// Decodes a 32 bpp BMP byte stream into RGB444 pixel writes. One file byte is
// taken per cycle while in_full is low; the header parser and pixel tracker in
// the front end finish each byte's work in the cycle it is accepted, and in_full
// rises only when the four-entry job queue backs up because results are not
// being popped. Only on-screen pixels and status changes produce results; once
// a status other than running is reported, further bytes are taken and dropped
// until reset.
// Configuration writes are always ready and should be issued while idle.
module bmp32_to_rgb444_blitter_core #(
  parameter int SCREEN_WIDTH = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int MAX_DIM = 4096
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire                                      in_push,
  output logic                                     in_full,
  input  bmpblt_pkg::in_item_t                     in_data,
  output logic                                     out_empty,
  input  wire                                      out_pop,
  output bmpblt_pkg::out_item_t                    out_data,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire [bmpblt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [bmpblt_pkg::ORG_W-1:0]              cfg_data
);

  logic                  byte_valid;
  logic                  job_push, job_pop, job_empty;
  bmpblt_pkg::job_t      job_wr, job_rd;
  bmpblt_pkg::img_dims_t dims;
  logic                  res_push, res_full;
  bmpblt_pkg::out_item_t res;
  bmpblt_pkg::cfg_regs_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign byte_valid = in_push && !in_full;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        bmpblt_pkg::CFG_ORIGIN_X: cfg_nxt.origin_x = cfg_data;
        bmpblt_pkg::CFG_ORIGIN_Y: cfg_nxt.origin_y = cfg_data;
        bmpblt_pkg::CFG_CENTER_MODE: cfg_nxt.center_mode = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bmpblt_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(byte_valid),
    .byte_in   (in_data),
    .job_push  (job_push),
    .job       (job_wr),
    .dims      (dims)
  );

  bmpblt_fifo #(
    .item_t(bmpblt_pkg::job_t),
    .DEPTH (bmpblt_pkg::ITEM_Q_DEPTH)
  ) u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_data(job_wr),
    .full   (in_full),
    .pop    (job_pop),
    .rd_data(job_rd),
    .empty  (job_empty)
  );

  bmpblt_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_empty(job_empty),
    .job_pop  (job_pop),
    .job      (job_rd),
    .dims     (dims),
    .cfg      (cfg_r),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  bmpblt_fifo #(
    .item_t(bmpblt_pkg::out_item_t),
    .DEPTH (bmpblt_pkg::RES_Q_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (res_push),
    .wr_data(res),
    .full   (res_full),
    .pop    (out_pop),
    .rd_data(out_data),
    .empty  (out_empty)
  );

  // a final status ends the stream: nothing follows it from the front end
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (job_push && job_wr.status != bmpblt_pkg::ST_RUN) |=> !job_push)
    else $error("job pushed after final status");

  // a result with no pixel exists only to carry a status
  a_empty_result_has_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_data.pixel_valid) |-> (out_data.status != bmpblt_pkg::ST_RUN))
    else $error("result without pixel or status");

  // the front end only emits jobs for accepted beats
  a_job_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> byte_valid)
    else $error("job without accepted beat");

  // back end never drops a result on a full output queue
  a_res_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

endmodule
`default_nettype wire
